// ===== rtl/core/rtcfe_pkg.sv =====
`timescale 1ns / 1ps

package rtcfe_pkg;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 14;
  localparam int unsigned YEAR_W      = 14;
  localparam int unsigned EPOCH_W     = 38;

  // register map
  localparam logic [CFG_INDEX_W-1:0] REG_CENTURY_ENABLE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PIVOT_YEAR     = 2'd1;

  localparam logic [YEAR_W-1:0] PIVOT_RESET = 14'd2024;
  localparam logic [YEAR_W-1:0] YEAR_EPOCH  = 14'd1970;
  localparam logic [YEAR_W-1:0] YEAR_MAX    = 14'd9999;

  // accumulator addend select
  localparam logic [2:0] ADD_YEAR      = 3'd0;
  localparam logic [2:0] ADD_LEAP_YEAR = 3'd1;
  localparam logic [2:0] ADD_MONTH     = 3'd2;
  localparam logic [2:0] ADD_DAY       = 3'd3;
  localparam logic [2:0] ADD_HOUR      = 3'd4;
  localparam logic [2:0] ADD_MINUTE    = 3'd5;
  localparam logic [2:0] ADD_SECOND    = 3'd6;

  typedef struct packed {
    logic       clear;
    logic       add;
    logic [2:0] sel;
    logic [3:0] month;
    logic       leap;
  } acc_ctl_t;

  typedef struct packed {
    logic [7:0] second;
    logic [7:0] minute;
    logic [7:0] hour;
    logic [7:0] day;
    logic [7:0] month;
    logic [7:0] year;
    logic [7:0] century;
    logic       pm_fix;
  } dec_t;

endpackage

// ===== rtl/core/rtcfe_if.sv =====
`timescale 1ns / 1ps

interface rtcfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_second;
  logic [7:0] raw_minute;
  logic [7:0] raw_hour;
  logic [7:0] raw_day;
  logic [7:0] raw_month;
  logic [7:0] raw_year;
  logic [7:0] raw_century;
  logic [7:0] status_b;

  modport source (
    output valid, raw_second, raw_minute, raw_hour, raw_day, raw_month, raw_year,
           raw_century, status_b,
    input  ready
  );
  modport sink (
    input  valid, raw_second, raw_minute, raw_hour, raw_day, raw_month, raw_year,
           raw_century, status_b,
    output ready
  );
endinterface

interface rtcfe_out_if;
  logic                            valid;
  logic                            ready;
  logic [rtcfe_pkg::EPOCH_W-1:0]   epoch_seconds;
  logic [rtcfe_pkg::YEAR_W-1:0]    full_year;
  logic                            invalid;

  modport source (output valid, epoch_seconds, full_year, invalid, input ready);
  modport sink   (input valid, epoch_seconds, full_year, invalid, output ready);
endinterface

interface rtcfe_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [rtcfe_pkg::CFG_INDEX_W-1:0]   index;
  logic [rtcfe_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/rtcfe_bcd.sv =====
`timescale 1ns / 1ps

module rtcfe_bcd (
  input  logic [7:0]      raw_second,
  input  logic [7:0]      raw_minute,
  input  logic [7:0]      raw_hour,
  input  logic [7:0]      raw_day,
  input  logic [7:0]      raw_month,
  input  logic [7:0]      raw_year,
  input  logic [7:0]      raw_century,
  input  logic [7:0]      status_b,
  output rtcfe_pkg::dec_t dec
);

  // nibbles above 9 pass unchecked
  function automatic logic [7:0] bcd(input logic [7:0] b);
    logic [7:0] tens;
    tens = {4'b0, b[7:4]};
    return {4'b0, b[3:0]} + (tens << 3) + (tens << 1);
  endfunction

  logic       binary_mode;
  logic [7:0] hr_tens;
  logic [7:0] hr_bcd;

  assign binary_mode = status_b[2];
  assign hr_tens     = {5'b0, raw_hour[6:4]};
  // low part stays below 128, so bit 7 ORs back cleanly
  assign hr_bcd      = ({4'b0, raw_hour[3:0]} + (hr_tens << 3) + (hr_tens << 1))
                       | {raw_hour[7], 7'b0};

  always_comb begin
    if (binary_mode) begin
      dec.second  = raw_second;
      dec.minute  = raw_minute;
      dec.hour    = raw_hour;
      dec.day     = raw_day;
      dec.month   = raw_month;
      dec.year    = raw_year;
      dec.century = raw_century;
    end else begin
      dec.second  = bcd(raw_second);
      dec.minute  = bcd(raw_minute);
      dec.hour    = hr_bcd;
      dec.day     = bcd(raw_day);
      dec.month   = bcd(raw_month);
      dec.year    = bcd(raw_year);
      dec.century = bcd(raw_century);
    end
    dec.pm_fix = !status_b[1] && dec.hour[7];
  end

endmodule

// ===== rtl/core/rtcfe_acc.sv =====
`timescale 1ns / 1ps

module rtcfe_acc (
  input  logic                          clk,
  input  rtcfe_pkg::acc_ctl_t           ctl,
  input  logic [7:0]                    second,
  output logic [rtcfe_pkg::EPOCH_W-1:0] total
);

  localparam int unsigned W = rtcfe_pkg::EPOCH_W;
  localparam logic [W-1:0] SECS_DAY   = 38'd86400;
  localparam logic [W-1:0] SECS_HOUR  = 38'd3600;
  localparam logic [W-1:0] SECS_MIN   = 38'd60;
  localparam logic [W-1:0] SECS_YEAR  = 38'd31536000;
  localparam logic [W-1:0] SECS_LEAPY = 38'd31622400;
  localparam logic [W-1:0] EPOCH_MAX  = 38'd253402300799;
  // day is summed as day*86400; one day comes off at the end
  localparam logic [W-1:0] OVER_LIM   = EPOCH_MAX + SECS_DAY;

  function automatic logic [W-1:0] month_secs(input logic [3:0] m, input logic leap);
    logic [W-1:0] s;
    case (m)
      4'd2:    s = leap ? 38'd2505600 : 38'd2419200;
      4'd4,
      4'd6,
      4'd9,
      4'd11:   s = 38'd2592000;
      default: s = 38'd2678400;
    endcase
    return s;
  endfunction

  logic [W-1:0] acc;
  logic [W-1:0] addend;

  always_comb begin
    case (ctl.sel)
      rtcfe_pkg::ADD_YEAR:      addend = SECS_YEAR;
      rtcfe_pkg::ADD_LEAP_YEAR: addend = SECS_LEAPY;
      rtcfe_pkg::ADD_MONTH:     addend = month_secs(ctl.month, ctl.leap);
      rtcfe_pkg::ADD_DAY:       addend = SECS_DAY;
      rtcfe_pkg::ADD_HOUR:      addend = SECS_HOUR;
      rtcfe_pkg::ADD_MINUTE:    addend = SECS_MIN;
      rtcfe_pkg::ADD_SECOND:    addend = {{(W-8){1'b0}}, second};
      default:                  addend = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (ctl.add) begin
      acc <= acc + addend;
    end
  end

  always_comb begin
    if (acc < SECS_DAY) begin
      total = '0;
    end else if (acc > OVER_LIM) begin
      total = EPOCH_MAX;
    end else begin
      total = acc - SECS_DAY;
    end
  end

endmodule

// ===== rtl/core/rtc_fields_to_epoch_seconds.sv =====
`timescale 1ns / 1ps
// Sequence: from input transfer to result valid the item passes the 12-hour fix, the pivot
//   reduction, the year walk (from 1970, or from year 0 for years before 1970), the month
//   walk and the day/hour/minute count-downs; a bad month goes straight to the result.
// Flow: one item in flight; a new item is taken once the previous one has
//   reached the output register, which may still be waiting to be taken.
// Reset: rst (synchronous, active high) idles the sequencer, drops result valid,
//   and sets century_enable = 0, pivot_year = 2024.
module rtc_fields_to_epoch_seconds (
  input  logic       clk,
  input  logic       rst,
  rtcfe_cfg_if.sink  cfg,
  rtcfe_in_if.sink   sample,
  rtcfe_out_if.source result
);

  localparam int unsigned YW = rtcfe_pkg::YEAR_W;
  localparam int unsigned EW = rtcfe_pkg::EPOCH_W;

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_HOUR   = 4'd1;   // 12-hour PM: add 12
  localparam logic [3:0] S_HMOD   = 4'd2;   // then reduce mod 24
  localparam logic [3:0] S_PIV    = 4'd3;   // pivot mod 100 by subtraction
  localparam logic [3:0] S_FULL   = 4'd4;   // raw full year
  localparam logic [3:0] S_INIT   = 4'd5;   // saturate, month check, walk setup
  localparam logic [3:0] S_YEARS  = 4'd6;
  localparam logic [3:0] S_MONTHS = 4'd7;
  localparam logic [3:0] S_DAY    = 4'd8;
  localparam logic [3:0] S_HR     = 4'd9;
  localparam logic [3:0] S_MIN    = 4'd10;
  localparam logic [3:0] S_SEC    = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;

  logic [3:0] state, state_next;

  // configuration
  logic          century_enable;
  logic [YW-1:0] pivot_year;

  // captured item
  rtcfe_pkg::dec_t dec_in;
  rtcfe_pkg::dec_t item;

  // working registers
  logic [YW-1:0] rem;        // pivot_year mod 100 when S_PIV ends, unless century_enable
  logic [14:0]   full_raw;   // up to 255 + 255*100
  logic [YW-1:0] full;
  logic          bad;
  logic [YW-1:0] yc;         // year being walked
  logic [1:0]    c4;         // yc mod 4
  logic [6:0]    c100;       // yc mod 100
  logic [8:0]    c400;       // yc mod 400
  logic [3:0]    mon_cnt;
  logic [7:0]    cnt;

  // result register
  logic          out_valid;
  logic [EW-1:0] out_epoch;
  logic [YW-1:0] out_year;
  logic          out_invalid;

  rtcfe_pkg::acc_ctl_t acc_ctl;
  logic [EW-1:0]       total;

  logic          leap_now;
  logic          month_bad;
  logic [14:0]   full_adj;
  logic [YW-1:0] full_sat;
  logic [14:0]   cen_x100;
  logic          done_go;
  logic          years_end;
  logic          months_end;

  rtcfe_bcd u_bcd (
    .raw_second  (sample.raw_second),
    .raw_minute  (sample.raw_minute),
    .raw_hour    (sample.raw_hour),
    .raw_day     (sample.raw_day),
    .raw_month   (sample.raw_month),
    .raw_year    (sample.raw_year),
    .raw_century (sample.raw_century),
    .status_b    (sample.status_b),
    .dec         (dec_in)
  );

  rtcfe_acc u_acc (
    .clk    (clk),
    .ctl    (acc_ctl),
    .second (item.second),
    .total  (total)
  );

  assign cfg.ready    = 1'b1;
  assign sample.ready = (state == S_IDLE);

  assign result.valid         = out_valid;
  assign result.epoch_seconds = out_epoch;
  assign result.full_year     = out_year;
  assign result.invalid       = out_invalid;

  // Gregorian rule from the running residues
  assign leap_now  = ((c4 == 2'd0) && (c100 != 7'd0)) || (c400 == 9'd0);
  assign month_bad = (item.month == 8'd0) || (item.month > 8'd12);

  // century * 100 as shifts
  assign cen_x100 = {1'b0, item.century, 6'b0} + {2'b0, item.century, 5'b0}
                  + {5'b0, item.century, 2'b0};

  // pivot expansion wraps into the next century when below the pivot
  assign full_adj = (!century_enable && (full_raw < {1'b0, pivot_year}))
                    ? full_raw + 15'd100 : full_raw;
  assign full_sat = (full_adj > {1'b0, rtcfe_pkg::YEAR_MAX})
                    ? rtcfe_pkg::YEAR_MAX : full_adj[YW-1:0];

  assign years_end  = (yc == full);
  assign months_end = ({4'b0, mon_cnt} == item.month);
  assign done_go    = !out_valid || result.ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (sample.valid) state_next = S_HOUR;
      S_HOUR:   state_next = item.pm_fix ? S_HMOD : S_PIV;
      S_HMOD:   if (item.hour < 8'd24) state_next = S_PIV;
      S_PIV:    if (century_enable || (rem < 14'd100)) state_next = S_FULL;
      S_FULL:   state_next = S_INIT;
      S_INIT:   state_next = month_bad ? S_DONE : S_YEARS;
      S_YEARS:  if (years_end) state_next = S_MONTHS;
      S_MONTHS: if (months_end) state_next = S_DAY;
      S_DAY:    if (cnt == 8'd0) state_next = S_HR;
      S_HR:     if (cnt == 8'd0) state_next = S_MIN;
      S_MIN:    if (cnt == 8'd0) state_next = S_SEC;
      S_SEC:    state_next = S_DONE;
      S_DONE:   if (done_go) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // shared adder control
  always_comb begin
    acc_ctl       = '0;
    acc_ctl.month = mon_cnt;
    acc_ctl.leap  = leap_now;
    case (state)
      S_INIT: acc_ctl.clear = 1'b1;
      S_YEARS: begin
        // only years from 1970 on count
        if (!years_end && (yc >= rtcfe_pkg::YEAR_EPOCH)) begin
          acc_ctl.add = 1'b1;
          acc_ctl.sel = leap_now ? rtcfe_pkg::ADD_LEAP_YEAR : rtcfe_pkg::ADD_YEAR;
        end
      end
      S_MONTHS: begin
        if (!months_end) begin
          acc_ctl.add = 1'b1;
          acc_ctl.sel = rtcfe_pkg::ADD_MONTH;
        end
      end
      S_DAY: begin
        acc_ctl.add = (cnt != 8'd0);
        acc_ctl.sel = rtcfe_pkg::ADD_DAY;
      end
      S_HR: begin
        acc_ctl.add = (cnt != 8'd0);
        acc_ctl.sel = rtcfe_pkg::ADD_HOUR;
      end
      S_MIN: begin
        acc_ctl.add = (cnt != 8'd0);
        acc_ctl.sel = rtcfe_pkg::ADD_MINUTE;
      end
      S_SEC: begin
        acc_ctl.add = 1'b1;
        acc_ctl.sel = rtcfe_pkg::ADD_SECOND;
      end
      default: acc_ctl = acc_ctl;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      century_enable <= 1'b0;
      pivot_year     <= rtcfe_pkg::PIVOT_RESET;
    end else begin
      state <= state_next;
      // a new result may replace one taken in the same cycle
      if ((state == S_DONE) && done_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg.valid) begin
        unique case (cfg.index)
          rtcfe_pkg::REG_CENTURY_ENABLE: century_enable <= cfg.data[0];
          rtcfe_pkg::REG_PIVOT_YEAR:     pivot_year     <= cfg.data;
          default:                       century_enable <= century_enable;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (sample.valid) begin
          item <= dec_in;
        end
      end
      S_HOUR: begin
        rem <= pivot_year;
        if (item.pm_fix) begin
          item.hour <= {1'b0, item.hour[6:0]} + 8'd12;
        end
      end
      S_HMOD: begin
        if (item.hour >= 8'd24) begin
          item.hour <= item.hour - 8'd24;
        end
      end
      S_PIV: begin
        if (rem >= 14'd100) begin
          rem <= rem - 14'd100;
        end
      end
      S_FULL: begin
        if (century_enable) begin
          full_raw <= {7'b0, item.year} + cen_x100;
        end else begin
          full_raw <= {7'b0, item.year} + {1'b0, pivot_year - rem};
        end
      end
      S_INIT: begin
        full    <= full_sat;
        bad     <= month_bad;
        mon_cnt <= 4'd1;
        // start the walk at 1970 when possible, else at year 0
        if (full_sat >= rtcfe_pkg::YEAR_EPOCH) begin
          yc   <= rtcfe_pkg::YEAR_EPOCH;
          c4   <= 2'd2;
          c100 <= 7'd70;
          c400 <= 9'd370;
        end else begin
          yc   <= '0;
          c4   <= '0;
          c100 <= '0;
          c400 <= '0;
        end
      end
      S_YEARS: begin
        if (!years_end) begin
          yc   <= yc + 14'd1;
          c4   <= c4 + 2'd1;
          c100 <= (c100 == 7'd99)  ? 7'd0 : c100 + 7'd1;
          c400 <= (c400 == 9'd399) ? 9'd0 : c400 + 9'd1;
        end
      end
      S_MONTHS: begin
        if (!months_end) begin
          mon_cnt <= mon_cnt + 4'd1;
        end else begin
          cnt <= item.day;
        end
      end
      S_DAY: begin
        if (cnt != 8'd0) cnt <= cnt - 8'd1;
        else             cnt <= item.hour;
      end
      S_HR: begin
        if (cnt != 8'd0) cnt <= cnt - 8'd1;
        else             cnt <= item.minute;
      end
      S_MIN: begin
        if (cnt != 8'd0) cnt <= cnt - 8'd1;
      end
      S_DONE: begin
        if (done_go) begin
          out_epoch   <= bad ? '0 : total;
          out_year    <= full;
          out_invalid <= bad;
        end
      end
      default: cnt <= cnt;
    endcase
  end

endmodule
